[hdl/octc_pkg.sv]
// Shared types, constants and helpers for the octree cell index block.
// Used by every module under hdl; depends on nothing else.
`timescale 1ns / 1ps

package octc_pkg;

  localparam int COORD_W       = 32;
  localparam int MAX_LEVEL_DEF = 7;
  localparam int IDX_W         = 22;
  localparam int DEPTH_W       = 3;
  localparam int LEVEL_W       = 3;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;

  localparam logic [CFG_DATA_W-1:0] INV_RESET = 32'h0001_0000;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_TREE_LEVEL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_X      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_Y      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INV_Z      = 3'd6;

  typedef struct packed {
    logic signed [COORD_W-1:0] corner_a_x;
    logic signed [COORD_W-1:0] corner_a_y;
    logic signed [COORD_W-1:0] corner_a_z;
    logic signed [COORD_W-1:0] corner_b_x;
    logic signed [COORD_W-1:0] corner_b_y;
    logic signed [COORD_W-1:0] corner_b_z;
  } octc_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]   cell_index;
    logic [DEPTH_W-1:0] cell_depth;
    logic               clamped;
  } octc_out_t;

  // Per-stage advance strobes of the pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } octc_adv_t;

  // Linear octree offset (8^depth - 1) / 7 for depth 0..8
  function automatic logic [23:0] octc_offset(input logic [3:0] depth);
    logic [23:0] acc;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < depth) begin
        acc = {acc[20:0], 3'b001};
      end
    end
    return acc;
  endfunction

endpackage

[hdl/octree_cell_index.sv]
// Top level of the octree cell index block: configuration registers, pipeline
// valid chain, six axis units and the Morton/index stage. Depends on octc_pkg,
// octc_axis and octc_morton.
`timescale 1ns / 1ps

// Takes one box (two corners in signed Q16.16) per cycle and returns the linear
// octree index of the smallest cell that holds it, its depth and a flag that
// is set when any corner coordinate had to be clamped into the region. The
// block is a five-stage pipeline: origin subtract, split multiply by the
// reciprocal cell size, floor and clamp, Morton interleave with shared-level
// search, then index assembly into the output register. One transaction is taken
// in every cycle as long as results are taken; a stalled output holds only the
// stages behind it that are full, so empty stages keep filling. Configuration
// registers may only be written while the pipeline is empty.
module octree_cell_index #(
  parameter int MAX_LEVEL = octc_pkg::MAX_LEVEL_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [octc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [octc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  octc_pkg::octc_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output octc_pkg::octc_out_t             out_data
);
  import octc_pkg::*;

  localparam int LVL_W = $clog2(MAX_LEVEL + 1);

  logic [LEVEL_W-1:0]          tree_level;
  logic [2:0][31:0]            origin;
  logic [2:0][31:0]            inv_cell;
  logic [LVL_W-1:0]            lvl;
  logic [MAX_LEVEL-1:0]        top;
  logic [5:0][COORD_W-1:0]     corners;
  logic [5:0][MAX_LEVEL-1:0]   cells;
  logic [5:0]                  clamps;
  logic                        v1, v2, v3, v4, v5;
  octc_adv_t                   adv;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tree_level <= '0;
      origin     <= '0;
      inv_cell   <= {3{INV_RESET}};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TREE_LEVEL: tree_level  <= cfg_data[LEVEL_W-1:0];
        REG_ORIGIN_X:   origin[0]   <= cfg_data;
        REG_ORIGIN_Y:   origin[1]   <= cfg_data;
        REG_ORIGIN_Z:   origin[2]   <= cfg_data;
        REG_INV_X:      inv_cell[0] <= cfg_data;
        REG_INV_Y:      inv_cell[1] <= cfg_data;
        REG_INV_Z:      inv_cell[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Saturate the level and build the largest cell coordinate
  always_comb begin
    if (int'(tree_level) > MAX_LEVEL) begin
      lvl = LVL_W'(MAX_LEVEL);
    end else begin
      lvl = LVL_W'(tree_level);
    end
    for (int i = 0; i < MAX_LEVEL; i++) begin
      top[i] = (LVL_W'(i) < lvl);
    end
  end

  // A stage advances when it is empty or the stage after it advances
  assign adv.s5   = !v5 || out_ready;
  assign adv.s4   = !v4 || adv.s5;
  assign adv.s3   = !v3 || adv.s4;
  assign adv.s2   = !v2 || adv.s3;
  assign adv.s1   = !v1 || adv.s2;
  assign in_ready = adv.s1;
  assign out_valid = v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (adv.s1) begin
        v1 <= in_valid;
      end
      if (adv.s2) begin
        v2 <= v1;
      end
      if (adv.s3) begin
        v3 <= v2;
      end
      if (adv.s4) begin
        v4 <= v3;
      end
      if (adv.s5) begin
        v5 <= v4;
      end
    end
  end

  assign corners[0] = in_data.corner_a_x;
  assign corners[1] = in_data.corner_a_y;
  assign corners[2] = in_data.corner_a_z;
  assign corners[3] = in_data.corner_b_x;
  assign corners[4] = in_data.corner_b_y;
  assign corners[5] = in_data.corner_b_z;

  for (genvar k = 0; k < 6; k++) begin : g_axis
    octc_axis #(
      .MAX_LEVEL (MAX_LEVEL)
    ) u_axis (
      .clk      (clk),
      .adv      (adv),
      .corner   (corners[k]),
      .origin   (origin[k % 3]),
      .inv_cell (inv_cell[k % 3]),
      .top      (top),
      .coord    (cells[k]),
      .clamp    (clamps[k])
    );
  end

  octc_morton #(
    .MAX_LEVEL (MAX_LEVEL),
    .LVL_W     (LVL_W)
  ) u_morton (
    .clk      (clk),
    .adv      (adv),
    .cell_a   (cells[2:0]),
    .cell_b   (cells[5:3]),
    .clamp    (|clamps),
    .lvl      (lvl),
    .out_data (out_data)
  );

  // An empty output register never blocks the input
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output register");

  // An accepted transaction occupies the first stage on the next cycle
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v1)
    else $error("accepted transaction lost at the first stage");

  // The index lies at or above the first index of its depth
  a_index_in_level: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (IDX_W'(octc_offset(4'(out_data.cell_depth))) <= out_data.cell_index))
    else $error("cell index below the start of its level");

endmodule

[hdl/octc_axis.sv]
// One corner coordinate on one axis: origin subtract, scale by the reciprocal
// cell size, floor and clamp to the finest level. Three pipeline stages.
// Depends on octc_pkg.
`timescale 1ns / 1ps

module octc_axis #(
  parameter int MAX_LEVEL = octc_pkg::MAX_LEVEL_DEF
) (
  input  logic                         clk,
  input  octc_pkg::octc_adv_t          adv,
  input  logic [octc_pkg::COORD_W-1:0] corner,
  input  logic [31:0]                  origin,
  input  logic [31:0]                  inv_cell,
  input  logic [MAX_LEVEL-1:0]         top,
  output logic [MAX_LEVEL-1:0]         coord,
  output logic                         clamp
);
  import octc_pkg::*;

  localparam int CW = COORD_W;
  // Magnitude is padded so that a high part always exists above bit 31
  localparam int DW = (CW > 32) ? CW : 33;

  logic [CW-1:0]        org_cw;
  logic signed [CW:0]   diff;
  logic [DW-1:0]        mag;
  logic                 neg1;
  logic [63:0]          prod_lo;
  logic [DW-1:0]        prod_hi;
  logic                 neg2;
  logic [DW:0]          sum;
  logic                 over;

  assign org_cw = CW'(origin);
  assign diff   = $signed({corner[CW-1], corner}) - $signed({org_cw[CW-1], org_cw});

  // Stage 1: offset from the region origin
  always_ff @(posedge clk) begin
    if (adv.s1) begin
      mag  <= DW'(diff[CW-1:0]);
      neg1 <= diff[CW];
    end
  end

  // Stage 2: split multiply, low 32 bits and the remaining high part
  always_ff @(posedge clk) begin
    if (adv.s2) begin
      prod_lo <= mag[31:0] * inv_cell;
      prod_hi <= mag[DW-1:32] * inv_cell;
      neg2    <= neg1;
    end
  end

  assign sum  = {1'b0, prod_hi} + (DW+1)'(prod_lo[63:32]);
  assign over = sum > (DW+1)'(top);

  // Stage 3: floor and clamp
  always_ff @(posedge clk) begin
    if (adv.s3) begin
      if (neg2) begin
        coord <= '0;
      end else if (over) begin
        coord <= top;
      end else begin
        coord <= sum[MAX_LEVEL-1:0];
      end
      clamp <= neg2 || over;
    end
  end

endmodule

[hdl/octc_morton.sv]
// Morton interleave of both corners, shared-cell search and linear index.
// Two pipeline stages; the second is the output register. Depends on octc_pkg.
`timescale 1ns / 1ps

module octc_morton #(
  parameter int MAX_LEVEL = octc_pkg::MAX_LEVEL_DEF,
  parameter int LVL_W     = $clog2(MAX_LEVEL + 1)
) (
  input  logic                          clk,
  input  octc_pkg::octc_adv_t           adv,
  input  logic [2:0][MAX_LEVEL-1:0]     cell_a,
  input  logic [2:0][MAX_LEVEL-1:0]     cell_b,
  input  logic                          clamp,
  input  logic [LVL_W-1:0]              lvl,
  output octc_pkg::octc_out_t           out_data
);
  import octc_pkg::*;

  localparam int MW   = 3 * MAX_LEVEL;
  localparam int SH_W = LVL_W + 2;

  logic [MW-1:0]    ma;
  logic [MW-1:0]    mb;
  logic [MW-1:0]    code_diff;
  logic [LVL_W-1:0] hi_next;
  logic [MW-1:0]    mb4;
  logic [LVL_W-1:0] hi4;
  logic             clamp4;
  logic [SH_W-1:0]  shamt;
  logic [MW-1:0]    space;
  logic [LVL_W-1:0] depth;
  logic [MW:0]      offset;
  logic [MW:0]      idx_sum;

  always_comb begin
    for (int i = 0; i < MAX_LEVEL; i++) begin
      ma[3*i]   = cell_a[0][i];
      ma[3*i+1] = cell_a[1][i];
      ma[3*i+2] = cell_a[2][i];
      mb[3*i]   = cell_b[0][i];
      mb[3*i+1] = cell_b[1][i];
      mb[3*i+2] = cell_b[2][i];
    end
  end

  assign code_diff = ma ^ mb;

  // Highest 3-bit group in which the codes differ
  always_comb begin
    hi_next = '0;
    for (int i = 0; i < MAX_LEVEL; i++) begin
      if (code_diff[3*i +: 3] != 3'b000) begin
        hi_next = LVL_W'(i + 1);
      end
    end
  end

  // Stage 4
  always_ff @(posedge clk) begin
    if (adv.s4) begin
      mb4    <= mb;
      hi4    <= hi_next;
      clamp4 <= clamp;
    end
  end

  assign shamt   = {hi4, 1'b0} + SH_W'(hi4);
  assign space   = mb4 >> shamt;
  assign depth   = lvl - hi4;
  assign offset  = (MW+1)'(octc_offset(4'(depth)));
  assign idx_sum = (MW+1)'(space) + offset;

  // Stage 5: output register
  always_ff @(posedge clk) begin
    if (adv.s5) begin
      out_data.cell_index <= IDX_W'(idx_sum);
      out_data.cell_depth <= DEPTH_W'(depth);
      out_data.clamped    <= clamp4;
    end
  end

endmodule

[verif/octree_cell_index_test.sv]
// Self-checking testbench for the octree cell index block: random and directed
// boxes against an in-bench predictor of the cell index. Depends on octc_pkg and
// octree_cell_index.
`timescale 1ns / 1ps

module octree_cell_index_test;
  import octc_pkg::*;

  localparam int STALL_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = 10;
  localparam int RANDOM_PHASES   = 12;
  localparam int BOXES_PER_PHASE = 85;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  octc_in_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  octc_out_t             out_data;

  // Shadow copy of the region registers
  logic [LEVEL_W-1:0]        level_q;
  logic signed [COORD_W-1:0] origin_q [3];
  logic [CFG_DATA_W-1:0]     inv_cell_q [3];

  octc_in_t  box_queue[$];
  octc_out_t expected_cells[$];
  octc_out_t oldest_cell;
  bit        steady = 1'b0;
  int        mismatches = 0;
  int        boxes_sent = 0;
  int        results_seen = 0;
  int        clamped_seen = 0;
  int        settings_used = 0;
  int        stall_cycles = 0;
  bit [7:0]  depths_seen = '0;

  octree_cell_index DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Cell coordinate of one corner on one axis, clamp flag in the top bit
  function automatic logic [7:0] cell_coord(input logic [31:0] corner, input int ax);
    logic [32:0] rel;
    logic [63:0] prod;
    logic [31:0] top;
    rel  = {corner[31], corner} - {origin_q[ax][31], origin_q[ax]};
    top  = (32'd1 << level_q) - 32'd1;
    prod = {32'd0, rel[31:0]} * {32'd0, inv_cell_q[ax]};
    if (rel[32]) begin
      return {1'b1, 7'd0};
    end
    if (prod[63:32] > top) begin
      return {1'b1, top[6:0]};
    end
    return {1'b0, prod[38:32]};
  endfunction

  function automatic octc_out_t predict_cell(input octc_in_t box);
    logic [2:0][7:0] ca, cb;
    logic [20:0]     code_a, code_b, split;
    logic [21:0]     offset;
    int              climb, depth;
    octc_out_t       result;
    ca[0] = cell_coord(box.corner_a_x, 0);
    ca[1] = cell_coord(box.corner_a_y, 1);
    ca[2] = cell_coord(box.corner_a_z, 2);
    cb[0] = cell_coord(box.corner_b_x, 0);
    cb[1] = cell_coord(box.corner_b_y, 1);
    cb[2] = cell_coord(box.corner_b_z, 2);
    code_a = '0;
    code_b = '0;
    for (int i = 0; i < level_q; i++) begin
      for (int ax = 0; ax < 3; ax++) begin
        code_a[3*i+ax] = ca[ax][i];
        code_b[3*i+ax] = cb[ax][i];
      end
    end
    // climb to the highest group in which the two codes disagree
    split = code_a ^ code_b;
    climb = 0;
    for (int i = 0; i < level_q; i++) begin
      if (split[3*i +: 3] != 3'd0) climb = i + 1;
    end
    depth  = level_q - climb;
    offset = '0;
    for (int i = 0; i < depth; i++) offset = offset * 22'd8 + 22'd1;
    result.cell_index = 22'(code_b >> (3 * climb)) + offset;
    result.cell_depth = depth[2:0];
    result.clamped    = ca[0][7] | ca[1][7] | ca[2][7] | cb[0][7] | cb[1][7] | cb[2][7];
    return result;
  endfunction

  // Width of the region along one axis, in Q16.16, capped to keep sums in range
  function automatic bit [63:0] axis_span(input int ax);
    bit [63:0] span;
    if (inv_cell_q[ax] == '0) begin
      span = 64'h1_0000_0000;
    end else begin
      span = ((64'd1 << level_q) << 32) / inv_cell_q[ax];
    end
    if (span > 64'h2_0000_0000) span = 64'h2_0000_0000;
    return span;
  endfunction

  function automatic logic [31:0] near_region(input int ax);
    bit [63:0] span, r;
    longint    rel;
    span = axis_span(ax);
    r    = {$urandom, $urandom};
    rel  = longint'(r % (span + span / 4 + 1)) - longint'(span / 8);
    return origin_q[ax] + 32'(rel);
  endfunction

  function automatic octc_in_t random_box();
    logic [2:0][31:0] a, b;
    bit [63:0]        step, delta;
    if ($urandom_range(99) < 15) begin
      return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end
    for (int ax = 0; ax < 3; ax++) begin
      a[ax] = near_region(ax);
      // mostly a small box, so that the shared cell sits at every depth
      step  = axis_span(ax) >> $urandom_range(0, level_q + 2);
      delta = {$urandom, $urandom} % (step + 1);
      if ($urandom_range(99) < 20) begin
        b[ax] = near_region(ax);
      end else if ($urandom_range(1)) begin
        b[ax] = a[ax] + 32'(delta);
      end else begin
        b[ax] = a[ax] - 32'(delta);
      end
    end
    return {a[0], a[1], a[2], b[0], b[1], b[2]};
  endfunction

  task automatic add_box(input logic [31:0] ax, ay, az, bx, by, bz);
    box_queue.insert(box_queue.size(), {ax, ay, az, bx, by, bz});
  endtask

  function automatic logic [31:0] q16(input int units);
    return 32'(units) << 16;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_TREE_LEVEL: level_q       = value[LEVEL_W-1:0];
      REG_ORIGIN_X:   origin_q[0]   = value;
      REG_ORIGIN_Y:   origin_q[1]   = value;
      REG_ORIGIN_Z:   origin_q[2]   = value;
      REG_INV_X:      inv_cell_q[0] = value;
      REG_INV_Y:      inv_cell_q[1] = value;
      REG_INV_Z:      inv_cell_q[2] = value;
      default: ;
    endcase
  endtask

  task automatic set_region(input int lvl, input logic [2:0][31:0] org,
                            input logic [2:0][31:0] inv);
    write_reg(REG_TREE_LEVEL, 32'(lvl));
    write_reg(REG_ORIGIN_X, org[0]);
    write_reg(REG_ORIGIN_Y, org[1]);
    write_reg(REG_ORIGIN_Z, org[2]);
    write_reg(REG_INV_X, inv[0]);
    write_reg(REG_INV_Y, inv[1]);
    write_reg(REG_INV_Z, inv[2]);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
    @(negedge clk);
  endtask

  // Return once every box has gone in and every result has come out
  task automatic wait_idle();
    do @(negedge clk);
    while (box_queue.size() != 0 || in_valid || expected_cells.size() != 0);
  endtask

  // Driver: predict on acceptance, then offer the next box or idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_cells.insert(expected_cells.size(), predict_cell(in_data));
        boxes_sent++;
      end
      if (!in_valid || in_ready) begin
        if (box_queue.size() != 0 && (steady || $urandom_range(99) >= 28)) begin
          in_valid <= 1'b1;
          in_data  <= box_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall at random and check each result transaction in order
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 28);
      if (out_valid && out_ready) begin
        if (expected_cells.size() == 0) begin
          $error("unexpected result: cell_index %0d, cell_depth %0d, clamped %0b",
                 out_data.cell_index, out_data.cell_depth, out_data.clamped);
          mismatches++;
        end else begin
          oldest_cell = expected_cells.pop_front();
          if (out_data.cell_index !== oldest_cell.cell_index) begin
            $error("cell_index: expected %0d, got %0d",
                   oldest_cell.cell_index, out_data.cell_index);
            mismatches++;
          end
          if (out_data.cell_depth !== oldest_cell.cell_depth) begin
            $error("cell_depth: expected %0d, got %0d",
                   oldest_cell.cell_depth, out_data.cell_depth);
            mismatches++;
          end
          if (out_data.clamped !== oldest_cell.clamped) begin
            $error("clamped: expected %0b, got %0b", oldest_cell.clamped, out_data.clamped);
            mismatches++;
          end
          results_seen++;
          clamped_seen += oldest_cell.clamped;
          depths_seen[oldest_cell.cell_depth] = 1'b1;
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("no transaction for %0d cycles, %0d results outstanding",
               stall_cycles, expected_cells.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int               lvl;
    logic [2:0][31:0] org, inv;
    level_q = '0;
    for (int ax = 0; ax < 3; ax++) begin
      origin_q[ax]   = '0;
      inv_cell_q[ax] = INV_RESET;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset values: every box folds into the root cell
    @(negedge clk);
    repeat (8) box_queue.insert(box_queue.size(), random_box());
    wait_idle();
    settings_used = 1;

    // unit cells on an 8 x 8 x 8 grid
    set_region(3, '0, {3{INV_RESET}});
    add_box(0, 0, 0, 0, 0, 0);
    add_box(q16(7) + 32'h8000, q16(7) + 32'h8000, q16(7) + 32'h8000,
            q16(7), q16(7), q16(7));
    add_box(0, 0, 0, q16(7), q16(7), q16(7));
    add_box(q16(1), 0, 0, 0, 0, 0);
    add_box(0, q16(2), 0, 0, 0, 0);
    add_box(0, 0, q16(4), 0, 0, 0);
    add_box(q16(2), q16(3), q16(1), q16(3), q16(2), q16(1));
    add_box(q16(5), q16(6), q16(4), q16(4), q16(7), q16(5));
    add_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_box(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0);
    add_box(q16(8), q16(8), q16(8), q16(8) - 1, q16(8) - 1, q16(8) - 1);
    add_box(32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, q16(1), q16(1), q16(1));
    add_box(32'h7FFF_FFFF, 0, 0, 0, 32'h8000_0000, 0);
    add_box(0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF);
    add_box(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      lvl = (p == 0 || p == 2) ? 7 : (p == 1) ? 0 : (p == 3) ? 5 : $urandom_range(7);
      for (int ax = 0; ax < 3; ax++) begin
        case ($urandom_range(5))
          0:       org[ax] = 32'h8000_0000;
          1:       org[ax] = 32'h7FFF_FFFF;
          default: org[ax] = $urandom;
        endcase
        case ($urandom_range(7))
          0:       inv[ax] = '0;
          1:       inv[ax] = '1;
          2:       inv[ax] = INV_RESET;
          default: inv[ax] = $urandom >> $urandom_range(0, 20);
        endcase
      end
      if (p == 0) begin
        org = {3{32'h8000_0000}};
        inv = {3{32'hFFFF_FFFF}};
      end
      if (p == 1) org = {3{32'h7FFF_FFFF}};
      if (p == 3) inv = '0;
      set_region(lvl, org, inv);
      steady = (p == 2);
      for (int n = 0; n < BOXES_PER_PHASE; n++) begin
        box_queue.insert(box_queue.size(), random_box());
        // hold the sender once until the pipeline has drained
        if (p == 4 && n == BOXES_PER_PHASE / 2) wait_idle();
      end
      wait_idle();
    end
    steady = 1'b0;

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_cells.size() != 0) begin
      $error("%0d results never arrived", expected_cells.size());
      mismatches++;
    end
    $display("%0d boxes over %0d region settings, levels 0 to 7, zero and full-scale scales",
             boxes_sent, settings_used);
    $display("%0d results checked, %0d clamped, depths seen %b",
             results_seen, clamped_seen, depths_seen);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
